// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the region table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define RTIL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define RTIL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/rtil_pkg.sv -----
// ----------------------------------------------------------------------------
// rtil_pkg
// Types, constants and helpers for the region table insert/lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package rtil_pkg;

    // Table geometry
    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 32;
    localparam int SLOT_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // Port field widths
    localparam int FIELD_W     = 32;
    localparam int OUT_SLOT_W  = 4;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_SLOT_W - 2 * FIELD_W;

    typedef logic [ADDR_BITS-1:0] t_rtil_addr;
    typedef logic [SLOT_W-1:0]    t_rtil_slot;
    typedef logic [CNT_W-1:0]     t_rtil_cnt;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_rtil_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } t_rtil_status;

    // Request token that walks the cell chain, collecting match results
    typedef struct packed {
        t_rtil_op   opcode;
        t_rtil_addr addr;
        t_rtil_addr len;
        logic       hit;
        logic       overlap;
        t_rtil_slot slot;
        t_rtil_addr hit_base;
        t_rtil_addr hit_len;
    } t_rtil_tok;

    // x < base + len, computed without wrap (as if the sum were one bit wider)
    function automatic logic fn_below_end(t_rtil_addr x, t_rtil_addr base, t_rtil_addr len);
        return (x < base) || ((x - base) < len);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rtil_cell.sv -----
// ----------------------------------------------------------------------------
// rtil_cell
// One table slot: stores a region and checks the passing token against it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtil_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtil_pkg::t_rtil_slot i_index,   // fixed slot number of this cell
    input  wire logic               i_used,      // slot holds a region
    input  wire logic               i_wr_en,
    input  wire rtil_pkg::t_rtil_addr i_wr_base,
    input  wire rtil_pkg::t_rtil_addr i_wr_len,
    input  wire logic               i_tok_valid,
    input  wire rtil_pkg::t_rtil_tok  i_tok,
    output logic                    o_tok_valid,
    output rtil_pkg::t_rtil_tok     o_tok
);
    import rtil_pkg::*;

    t_rtil_addr r_base;
    t_rtil_addr r_len;
    logic       r_tok_valid;
    t_rtil_tok  r_tok;
    t_rtil_tok  n_tok;
    logic       w_hit;
    logic       w_ovl;

    // Stored region, written once when the slot is filled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_base <= i_wr_base;
            r_len  <= i_wr_len;
        end
    end

    // Compare the token against this slot
    always_comb begin
        w_hit = i_used && (i_tok.opcode == OP_LOOKUP) && !(i_tok.addr < r_base)
                && ((i_tok.addr - r_base) < r_len);
        w_ovl = i_used && (i_tok.opcode == OP_INSERT)
                && fn_below_end(r_base, i_tok.addr, i_tok.len)
                && fn_below_end(i_tok.addr, r_base, r_len);
        n_tok = i_tok;
        n_tok.overlap = i_tok.overlap | w_ovl;
        // later slots overwrite earlier ones: newest match wins
        if (w_hit) begin
            n_tok.hit      = 1'b1;
            n_tok.slot     = i_index;
            n_tok.hit_base = r_base;
            n_tok.hit_len  = r_len;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

`default_nettype wire

// ----- hw/rtl/region_table_insert_lookup_top.sv -----
// ----------------------------------------------------------------------------
// region_table_insert_lookup_top
// Region table with overlap-checked insert and address lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser = opcode (0 insert, 1 lookup), tdata holds
//   addr and length. Output stream (m_axis): tuser = status, tdata holds
//   slot, region_base and region_length. One result per input transfer.
//   A request token walks a row of MAX_REGIONS cells, one cell per cycle,
//   each cell holding one stored region. The result leaves the last cell
//   into a holding register, then moves to the output register, and the
//   next input is taken only after the result is loaded, so the block takes
//   no new request while one is in flight. An insert that passes the overlap
//   check and finds the table not full fills the next free slot.
//   Reset empties the table (fill count to zero) and drops any item in
//   flight. If the receiver stalls, the finished result waits in a holding
//   register and s_axis_tready stays low until it has been passed on; one
//   more result may sit in the output register meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module region_table_insert_lookup_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rtil_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // addr[31:0], length[63:32]
    input  wire logic [rtil_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // opcode[0]
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [rtil_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // slot[3:0], region_base[35:4],
                                                                // region_length[67:36], zero pad
    output logic [rtil_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // status[1:0]
);
    import rtil_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state       r_state;
    t_rtil_cnt    r_used_count;
    logic         r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser;
    t_rtil_status r_res_status;
    t_rtil_slot   r_res_slot;
    t_rtil_addr   r_res_base;
    t_rtil_addr   r_res_len;

    logic         w_vld [MAX_REGIONS+1];
    t_rtil_tok    w_tok [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0] w_busy;
    logic         w_in_xfer;
    logic         w_exit;
    logic         w_full;
    logic         w_wr_en;
    logic         w_load;
    t_rtil_tok    w_head;
    t_rtil_status n_status;
    t_rtil_slot   n_slot;
    t_rtil_addr   n_base;
    t_rtil_addr   n_len;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Build the token from the input transfer
    always_comb begin
        w_head          = '0;
        w_head.opcode   = t_rtil_op'(s_axis_tuser[0]);
        w_head.addr     = ADDR_BITS'(s_axis_tdata[FIELD_W-1:0]);
        w_head.len      = ADDR_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    end

    assign w_vld[0] = w_in_xfer;
    assign w_tok[0] = w_head;

    // Row of cells, one per slot
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        rtil_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (SLOT_W'(g)),
            .i_used      (CNT_W'(g) < r_used_count),
            .i_wr_en     (w_wr_en && (r_used_count == CNT_W'(g))),
            .i_wr_base   (w_tok[MAX_REGIONS].addr),
            .i_wr_len    (w_tok[MAX_REGIONS].len),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
        assign w_busy[g] = w_vld[g+1];
    end

    // Result of the token leaving the last cell
    assign w_exit  = w_vld[MAX_REGIONS];
    assign w_full  = (r_used_count >= CNT_W'(MAX_REGIONS));
    assign w_wr_en = w_exit && (w_tok[MAX_REGIONS].opcode == OP_INSERT)
                     && !w_tok[MAX_REGIONS].overlap && !w_full;

    always_comb begin
        n_status = ST_OK;
        n_slot   = '0;
        n_base   = '0;
        n_len    = '0;
        unique case (w_tok[MAX_REGIONS].opcode)
            OP_INSERT: begin
                priority if (w_tok[MAX_REGIONS].overlap) begin
                    n_status = ST_OVERLAP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_slot = SLOT_W'(r_used_count);
                end
            end
            OP_LOOKUP: begin
                if (w_tok[MAX_REGIONS].hit) begin
                    n_slot = w_tok[MAX_REGIONS].slot;
                    n_base = w_tok[MAX_REGIONS].hit_base;
                    n_len  = w_tok[MAX_REGIONS].hit_len;
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: n_status = ST_MISS;
        endcase
    end

    // Held result moves to the output register when that is free
    assign w_load = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    // Sequencer, fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_exit) begin
                        r_state      <= S_HOLD;
                        r_res_status <= n_status;
                        r_res_slot   <= n_slot;
                        r_res_base   <= n_base;
                        r_res_len    <= n_len;
                        if (w_wr_en) begin
                            r_used_count <= CNT_W'(r_used_count + 1'b1);
                        end
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        r_out_tuser <= OUT_TUSER_W'(r_res_status);
                        r_out_tdata <= {{OUT_PAD_W{1'b0}}, FIELD_W'(r_res_len),
                                        FIELD_W'(r_res_base), OUT_SLOT_W'(r_res_slot)};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // Checks
    `RTIL_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_used_count > CNT_W'(MAX_REGIONS), "fill count above capacity")
    `RTIL_ASSERT(a_exit_in_run, i_clk, i_rst_n, w_exit |-> r_state == S_RUN, "token left chain outside run state")
    `RTIL_ASSERT(a_fill_step, i_clk, i_rst_n, w_wr_en |=> r_used_count == $past(r_used_count) + 1'b1, "fill count did not advance on insert")
    `RTIL_ASSERT(a_accept_empty, i_clk, i_rst_n, w_in_xfer |-> w_busy == '0, "input taken while chain busy")

endmodule

`default_nettype wire

// ----- tb/region_table_insert_lookup_top_test.sv -----
// ----------------------------------------------------------------------------
// region_table_insert_lookup_top_test
// Self-checking bench for the region table insert/lookup block.
// ----------------------------------------------------------------------------
// Requests go in on the input stream and are mirrored into a local copy of
// the table at the moment of each transfer. The bench computes the reply
// there and queues it. Each reply that leaves the block is compared field
// by field with the oldest queued one. Directed tests walk through overlap
// edges, zero-length regions, the top and bottom of the address space and
// the full table. Random traffic with random gaps on both sides follows,
// plus one long output stall and one stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module region_table_insert_lookup_top_test;

    import rtil_pkg::*;

    localparam int HOLD_CYCLES = 300;                    // long output stall
    localparam int STALL_LIMIT = 4000;                   // quiet cycles before giving up
    localparam int DRAIN_CYCLES = 2 * (MAX_REGIONS + 2); // latency margin at the end

    typedef struct {
        t_rtil_status status;
        logic [3:0]   slot;
        t_rtil_addr   base;
        t_rtil_addr   length;
    } t_region_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // addr[31:0], length[63:32]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // opcode[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // slot[3:0], region_base[35:4],
                                            // region_length[67:36], zero pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // status[1:0]

    // Local copy of the region table
    t_rtil_addr tbl_base [MAX_REGIONS];
    t_rtil_addr tbl_len  [MAX_REGIONS];
    int         tbl_count = 0;

    t_region_reply pending_replies[$];

    int  mismatch_count = 0;
    int  requests_sent  = 0;
    int  replies_seen   = 0;
    int  stored_count   = 0;
    int  overlap_count  = 0;
    int  full_count     = 0;
    int  hit_count      = 0;
    int  miss_count     = 0;
    bit  calm           = 1'b0;   // no random gaps on either side
    bit  hold_toggle    = 1'b0;   // flipped to request one long output stall

    region_table_insert_lookup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // x lies below base + len, sum taken 33 bits wide
    function automatic bit below_region_end(t_rtil_addr x, t_rtil_addr base, t_rtil_addr len);
        return {1'b0, x} < ({1'b0, base} + {1'b0, len});
    endfunction

    // Apply one request to the local table and return the reply it gives
    function automatic t_region_reply predict_table_reply(t_rtil_op op, t_rtil_addr a,
                                                          t_rtil_addr len);
        t_region_reply r;
        bit            clash;
        r = '{status: ST_OK, slot: '0, base: '0, length: '0};
        if (op == OP_INSERT) begin
            clash = 1'b0;
            for (int i = 0; i < tbl_count; i++) begin
                if (below_region_end(tbl_base[i], a, len) &&
                    below_region_end(a, tbl_base[i], tbl_len[i]))
                    clash = 1'b1;
            end
            // overlap takes priority over a full table
            if (clash) begin
                r.status = ST_OVERLAP;
                overlap_count++;
            end else if (tbl_count >= MAX_REGIONS) begin
                r.status = ST_FULL;
                full_count++;
            end else begin
                tbl_base[tbl_count] = a;
                tbl_len[tbl_count]  = len;
                r.slot = 4'(tbl_count);
                tbl_count++;
                stored_count++;
            end
        end else begin
            // newest slot wins
            r.status = ST_MISS;
            for (int i = tbl_count - 1; i >= 0; i--) begin
                if (r.status == ST_MISS && a >= tbl_base[i] &&
                    below_region_end(a, tbl_base[i], tbl_len[i])) begin
                    r.status = ST_OK;
                    r.slot   = 4'(i);
                    r.base   = tbl_base[i];
                    r.length = tbl_len[i];
                end
            end
            if (r.status == ST_OK)
                hit_count++;
            else
                miss_count++;
        end
        return r;
    endfunction

    // Address at, next to or inside a stored region; table must not be empty
    function automatic t_rtil_addr addr_near_region();
        int unsigned i;
        t_rtil_addr  b;
        t_rtil_addr  l;
        i = $urandom_range(tbl_count - 1);
        b = tbl_base[i];
        l = tbl_len[i];
        case ($urandom_range(4))
            0: return b;
            1: return b - 1;
            2: return b + l;
            3: return b + l - 1;
            default: return (l == 0) ? b : b + ($urandom % l);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void compare_field(string name, int idx, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("reply %0d %s: expected 0x%0h, got 0x%0h",
                                    idx, name, want, got));
    endfunction

    task automatic check_reply();
        t_region_reply want;
        replies_seen++;
        if (pending_replies.size() == 0) begin
            note_mismatch($sformatf("reply %0d arrived with nothing outstanding",
                                    replies_seen));
            return;
        end
        want = pending_replies.pop_front();
        compare_field("status", replies_seen, 32'(want.status), 32'(m_axis_tuser[1:0]));
        compare_field("slot", replies_seen, 32'(want.slot), 32'(m_axis_tdata[3:0]));
        compare_field("region_base", replies_seen, want.base, m_axis_tdata[35:4]);
        compare_field("region_length", replies_seen, want.length, m_axis_tdata[67:36]);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request; returns at the edge where the transfer happens
    task automatic send_request(t_rtil_op op, t_rtil_addr a, t_rtil_addr len);
        while (!calm && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {len, a};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        pending_replies.push_back(predict_table_reply(op, a, len));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_table();
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_insert_and_overlap();
        send_request(OP_INSERT, 32'h0000_1000, 32'h0000_0100);
        send_request(OP_INSERT, 32'h0000_1000, 32'h0000_0100);  // exact duplicate
        send_request(OP_INSERT, 32'h0000_0F00, 32'h0000_0101);  // one byte into it
        send_request(OP_INSERT, 32'h0000_0F00, 32'h0000_0100);  // touches, no overlap
        send_request(OP_LOOKUP, 32'h0000_0FFF, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_10FF, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_1100, 32'h0000_0000);
    endtask

    task automatic test_zero_length();
        send_request(OP_INSERT, 32'h0000_1080, 32'h0000_0000);  // strictly inside
        send_request(OP_INSERT, 32'h0000_1100, 32'h0000_0000);  // at an end
        send_request(OP_INSERT, 32'h0000_3000, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_2F00, 32'h0000_0200);  // spans the point
        send_request(OP_INSERT, 32'h0000_3000, 32'h0000_0100);  // starts at the point
        send_request(OP_LOOKUP, 32'h0000_3000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_1100, 32'h0000_0000);
    endtask

    task automatic test_address_extremes();
        send_request(OP_INSERT, 32'hFFFF_FF00, 32'h0000_0100);  // end is 2^32
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FF00);
        send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'hFFFF_FEFF, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    // Mixed inserts and lookups, biased toward region edges
    task automatic test_random_traffic(int n_items);
        t_rtil_op   op;
        t_rtil_addr a;
        t_rtil_addr len;
        for (int k = 0; k < n_items; k++) begin
            op  = ($urandom_range(99) < 35) ? OP_INSERT : OP_LOOKUP;
            len = $urandom >> $urandom_range(0, 31);
            if (tbl_count != 0 && $urandom_range(99) < 60)
                a = addr_near_region();
            else
                a = $urandom;
            if (op == OP_INSERT && $urandom_range(3) == 0)
                a = a - len;    // region that ends at the chosen point
            send_request(op, a, len);
        end
    endtask

    // Receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_stall();
        calm = 1'b1;
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 16; k++)
            send_request(OP_LOOKUP, (tbl_count != 0) ? addr_near_region() : $urandom,
                         $urandom);
        calm = 1'b0;
    endtask

    task automatic test_steady_stream(int n_items);
        calm = 1'b1;
        test_random_traffic(n_items);
        calm = 1'b0;
    endtask

    task automatic test_full_table();
        // zero-length regions at address 0 never clash, so they always fill slots
        while (tbl_count < MAX_REGIONS)
            send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_1000, 32'h0000_0001);  // overlap while full
        send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);  // full
        send_request(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000);
    endtask

    // ------------------------------------------------------------------
    // Reply side: random ready, one long stall on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                check_reply();
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 36);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles, %0d replies outstanding",
                 STALL_LIMIT, pending_replies.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_insert_and_overlap();
        test_zero_length();
        test_address_extremes();
        test_random_traffic(320);
        test_output_stall();
        test_steady_stream(150);
        test_full_table();
        test_random_traffic(280);
        s_axis_tvalid <= 1'b0;

        // wait for every reply, then watch for strays
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0)
            note_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

        $display("covered %0d requests / %0d replies: %0d stored, %0d overlap, %0d full,",
                 requests_sent, replies_seen, stored_count, overlap_count, full_count);
        $display("  %0d lookup hits, %0d misses, one %0d-cycle output stall, full-rate burst",
                 hit_count, miss_count, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
